>>> rtl/mfsf_pkg.sv
package mfsf_pkg;

  // Command codes carried on in_tuser.
  typedef enum logic [2:0] {
    MODE_CLEAR       = 3'd0,
    MODE_CHECKER     = 3'd1,
    MODE_SCROLL_ROWS = 3'd2,
    MODE_SCROLL_COLS = 3'd3,
    MODE_READ        = 3'd4
  } mode_t;

  // Kind of write performed by one sweep over the store.
  typedef enum logic [2:0] {
    OP_INIT,
    OP_FILL,
    OP_CHECK,
    OP_ROWS,
    OP_COLS
  } sweep_op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_DECODE,
    ST_ROWPAT,
    ST_SWEEP,
    ST_RD_ADDR,
    ST_RD_WAIT
  } ctrl_state_t;

  // Input beat layout.
  localparam int MODE_W       = 3;
  localparam int IN_TDATA_W   = 24;
  localparam int OUT_TDATA_W  = 64;
  localparam int CELL_LSB     = 0;
  localparam int CELL_W       = 7;
  localparam int SHIFT_LSB    = 7;
  localparam int SHIFT_W      = 8;
  localparam int FILL_BIT     = 15;
  localparam int COL_LSB      = 16;
  localparam int COL_W        = 7;

  typedef struct packed {
    logic      capture;
    logic      row_start;
    logic      row_step;
    logic      sweep_start;
    logic      sweep_step;
    sweep_op_t op;
    logic      rd_issue;
    logic      out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  shift_zero;
    logic  rows_big;
    logic  cols_big;
    logic  row_last;
    logic  sweep_last;
    logic  out_free;
  } dp_status_t;

endpackage

>>> rtl/mono_framebuffer_scroll_fill.sv
// A clear or a nonzero scroll sweeps every column once; a zero scroll or an unused mode returns
// to idle with no write. Checkerboard first builds the row pattern and then sweeps; a column read
// is held while the previous result still waits in the output register.
// Fill and scroll commands walk the column store through one read and one write port, one column
// a cycle. Reset is synchronous and active low; afterwards the store is zeroed in a pass during
// which no input beat is taken.
module mono_framebuffer_scroll_fill
  import mfsf_pkg::*;
#(
  parameter int NUM_COLUMNS = 128,
  parameter int NUM_ROWS    = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // in_tdata, from bit 0 up: cell_width[6:0], shift_amount[14:7], fill_ones[15],
  // column[22:16], zero padding[23].
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: mode[2:0].
  input  logic [MODE_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // out_tdata: column_bits[63:0], bit i is pixel row i; rows at and above NUM_ROWS read zero.
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  // The controller sequences each command: it takes a beat only when idle, decodes it in the
  // following cycle, then builds the checkerboard row pattern and sweeps, runs a sweep over all
  // columns, performs a single column read, or, for a zero scroll or an unused mode, goes idle.
  // The datapath holds the command fields, the column store and the single output register; a
  // read result waits there without blocking later fill or scroll commands.
  ctrl_cmd_t  cmd;
  dp_status_t sts;

  mfsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The sweep is a two stage loop: the column address (or, for a column scroll, its
  // source) is read in the first cycle and the new word is written in the next. Column
  // scrolls toward higher indices walk downward so no source is overwritten before use.
  mfsf_dp #(
    .NUM_COLUMNS (NUM_COLUMNS),
    .NUM_ROWS    (NUM_ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> rtl/mfsf_ram.sv
module mfsf_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/mfsf_ctrl.sv
module mfsf_ctrl
  import mfsf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  dp_status_t sts,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.op    = OP_INIT;
    in_tready = 1'b0;
    unique case (state_r)
      ST_INIT: begin
        // Zero the whole store once after reset.
        cmd.sweep_start = 1'b1;
        cmd.op          = OP_INIT;
        state_nxt       = ST_SWEEP;
      end
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        unique case (sts.mode)
          MODE_CLEAR: begin
            cmd.sweep_start = 1'b1;
            cmd.op          = OP_FILL;
            state_nxt       = ST_SWEEP;
          end
          MODE_CHECKER: begin
            cmd.row_start = 1'b1;
            state_nxt     = ST_ROWPAT;
          end
          MODE_SCROLL_ROWS: begin
            if (!sts.shift_zero) begin
              cmd.sweep_start = 1'b1;
              cmd.op          = sts.rows_big ? OP_FILL : OP_ROWS;
              state_nxt       = ST_SWEEP;
            end
          end
          MODE_SCROLL_COLS: begin
            if (!sts.shift_zero) begin
              cmd.sweep_start = 1'b1;
              cmd.op          = sts.cols_big ? OP_FILL : OP_COLS;
              state_nxt       = ST_SWEEP;
            end
          end
          MODE_READ: begin
            state_nxt = ST_RD_ADDR;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_ROWPAT: begin
        cmd.row_step = 1'b1;
        if (sts.row_last) begin
          cmd.sweep_start = 1'b1;
          cmd.op          = OP_CHECK;
          state_nxt       = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD_ADDR: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        cmd.rd_issue = 1'b1;
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/mfsf_dp.sv
module mfsf_dp
  import mfsf_pkg::*;
#(
  parameter int NUM_COLUMNS = 128,
  parameter int NUM_ROWS    = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ctrl_cmd_t              cmd,
  output dp_status_t             sts,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [MODE_W-1:0]      in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW  = $clog2(NUM_COLUMNS);
  localparam int RW  = $clog2(NUM_ROWS);
  localparam int CXW = (AW > COL_W) ? AW : COL_W;
  localparam int SW  = ((AW > SHIFT_W) ? AW : SHIFT_W) + 2;
  localparam logic [AW-1:0]        LAST_IDX = AW'(NUM_COLUMNS - 1);
  localparam logic [RW-1:0]        LAST_ROW = RW'(NUM_ROWS - 1);
  localparam logic signed [SW-1:0] NCS      = SW'(NUM_COLUMNS);

  // Captured command fields.
  mode_t                      mode_r;
  logic [CELL_W-1:0]          cell_r;
  logic signed [SHIFT_W-1:0]  shift_r;
  logic                       ones_r;
  logic [COL_W-1:0]           col_r;

  // Sweep issue stage.
  sweep_op_t                  op_r;
  logic                       desc_r;
  logic [AW-1:0]              idx_r;

  // Cell-size divider: counts pixels inside a cell and flips parity per cell.
  logic [CELL_W-1:0]          dcnt_r;
  logic                       dpar_r;
  logic [RW-1:0]              row_r;
  logic [NUM_ROWS-1:0]        pat_r;

  // Write stage.
  logic                       wv_r;
  logic [AW-1:0]              wa_r;
  logic                       wpar_r;
  logic                       wsrc_ok_r;

  logic                       out_valid_r;
  logic [OUT_TDATA_W-1:0]     out_data_r;

  logic [8:0]                 mag;
  logic signed [SW-1:0]       src_s;
  logic                       src_ok;
  logic [CXW-1:0]             col_x;
  logic                       col_ok;
  logic [AW-1:0]              raddr;
  logic [NUM_ROWS-1:0]        rdata;
  logic [NUM_ROWS-1:0]        wdata;
  logic [NUM_ROWS-1:0]        bg;
  logic [NUM_ROWS-1:0]        all_ones;
  logic                       div_adv;

  assign all_ones = '1;
  assign bg       = {NUM_ROWS{ones_r}};
  assign mag      = shift_r[SHIFT_W-1] ? (9'd0 - {1'b1, shift_r}) : {1'b0, shift_r};
  assign src_s    = $signed({1'b0, idx_r}) - SW'(shift_r);
  assign src_ok   = (src_s >= 0) && (src_s < NCS);
  assign col_x    = CXW'(col_r);
  assign col_ok   = int'(col_r) < NUM_COLUMNS;
  assign div_adv  = cmd.row_step || (cmd.sweep_step && (op_r == OP_CHECK));

  always_comb begin
    if (cmd.rd_issue) begin
      raddr = col_x[AW-1:0];
    end else if (op_r == OP_COLS) begin
      raddr = src_s[AW-1:0];
    end else begin
      raddr = idx_r;
    end
  end

  always_comb begin
    case (op_r)
      OP_FILL:  wdata = bg;
      OP_CHECK: wdata = (wpar_r ? pat_r : ~pat_r) ^ bg;
      OP_ROWS: begin
        if (shift_r[SHIFT_W-1]) begin
          wdata = (rdata >> mag) | (ones_r ? ~(all_ones >> mag) : '0);
        end else begin
          wdata = (rdata << mag) | (ones_r ? ~(all_ones << mag) : '0);
        end
      end
      OP_COLS:  wdata = wsrc_ok_r ? rdata : bg;
      default:  wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= mode_t'(in_tuser);
      cell_r  <= in_tdata[CELL_LSB +: CELL_W];
      shift_r <= in_tdata[SHIFT_LSB +: SHIFT_W];
      ones_r  <= in_tdata[FILL_BIT];
      col_r   <= in_tdata[COL_LSB +: COL_W];
    end

    if (cmd.sweep_start) begin
      op_r   <= cmd.op;
      desc_r <= (cmd.op == OP_COLS) && !shift_r[SHIFT_W-1];
      idx_r  <= ((cmd.op == OP_COLS) && !shift_r[SHIFT_W-1]) ? LAST_IDX : '0;
    end else if (cmd.sweep_step) begin
      idx_r <= desc_r ? idx_r - 1'b1 : idx_r + 1'b1;
    end

    if (cmd.sweep_start || cmd.row_start) begin
      dcnt_r <= '0;
      dpar_r <= 1'b0;
    end else if (div_adv && (cell_r != '0)) begin
      if (dcnt_r == cell_r - 1'b1) begin
        dcnt_r <= '0;
        dpar_r <= ~dpar_r;
      end else begin
        dcnt_r <= dcnt_r + 1'b1;
      end
    end

    if (cmd.row_start) begin
      row_r <= '0;
    end else if (cmd.row_step) begin
      row_r <= row_r + 1'b1;
      pat_r <= {dpar_r, pat_r[NUM_ROWS-1:1]};
    end

    wa_r      <= idx_r;
    wpar_r    <= dpar_r;
    wsrc_ok_r <= src_ok;

    if (cmd.out_load) begin
      out_data_r <= col_ok ? OUT_TDATA_W'(rdata) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wv_r <= cmd.sweep_step;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  mfsf_ram #(
    .WIDTH (NUM_ROWS),
    .DEPTH (NUM_COLUMNS)
  ) u_store (
    .clk   (clk),
    .we    (wv_r),
    .waddr (wa_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    sts.mode       = mode_r;
    sts.shift_zero = (shift_r == '0);
    sts.rows_big   = int'(mag) >= NUM_ROWS;
    sts.cols_big   = int'(mag) >= NUM_COLUMNS;
    sts.row_last   = (row_r == LAST_ROW);
    sts.sweep_last = desc_r ? (idx_r == '0) : (idx_r == LAST_IDX);
    sts.out_free   = !out_valid_r || out_tready;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
